// ----- src/serial_frame_gap_and_retry_watchdog_top_macros.svh -----
// Assertion macros for the serial frame gap and retry watchdog block.
`ifndef SERIAL_FRAME_GAP_AND_RETRY_WATCHDOG_TOP_MACROS_SVH
`define SERIAL_FRAME_GAP_AND_RETRY_WATCHDOG_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SFGR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfgrw check failed");
`define SFGR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfgrw check failed");
`else
`define SFGR_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SFGR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- src/sfgrw_pkg.sv -----
// Shared types, constants and helpers for the frame gap and retry watchdog block.
package sfgrw_pkg;

   localparam int STORE_DEPTH_DEF = 64;
   localparam int REQ_DATA_W      = 48;
   localparam int RSP_DATA_W      = 16;
   localparam int CSR_INDEX_W     = 8;
   localparam int CSR_DATA_W      = 16;

   localparam logic [7:0]  GAP_TICKS_RST   = 8'd3;
   localparam logic [15:0] REPLY_WAIT_RST  = 16'd50;
   localparam logic [15:0] RECOVER_RST     = 16'd250;
   localparam logic [1:0]  MAX_RETRY_RST   = 2'd1;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_USS    = 2'd1,
      KIND_MODBUS = 2'd2,
      KIND_POP    = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAP_TICKS  = 8'd0,
      CSR_REPLY_WAIT = 8'd1,
      CSR_RECOVER    = 8'd2,
      CSR_MAX_RETRY  = 8'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STAT_OUT,
      ST_POP_RD,
      ST_POP_OUT,
      ST_RUN_RD,
      ST_RUN_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      SEL_STATUS,
      SEL_POP,
      SEL_RUN
   } out_sel_type;

   typedef struct packed {
      logic        take;
      logic        rd_step;
      logic        load;
      out_sel_type sel;
      logic        last;
   } dp_cmd_type;

   typedef struct packed {
      logic is_pop;
      logic pop_hit;
      logic dispatch;
      logic run_done;
      logic out_free;
   } dp_sts_type;

   function automatic logic reached(input logic [31:0] now, input logic [31:0] deadline);
      logic [31:0] diff;
      diff = now - deadline;
      return ~diff[31];
   endfunction

endpackage

// ----- src/sfgrw_ram.sv -----
// Generic single write port RAM with registered read.
module sfgrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/sfgrw_dp.sv -----
// Datapath: configuration, frame store, gap and watchdog state, result register.
module sfgrw_dp
   import sfgrw_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_sts_type             sts,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STORE_DEPTH);
   localparam logic [SW-1:0] WRAP_SUM = SW'(STORE_DEPTH);

   logic [31:0] now;
   logic        rx_valid;
   logic [7:0]  rx_data;
   logic        ready_set;
   logic        ready_clear;
   logic        fmt_wait;
   logic        uss_wait_set;
   logic        alt_drive_wait;

   logic [7:0]  gap_ticks_ff, gap_ticks_in;
   logic [15:0] reply_wait_ff, reply_wait_in;
   logic [15:0] recover_ff, recover_in;
   logic [1:0]  max_retry_ff, max_retry_in;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   gap_dl_ff, gap_dl_in;
   logic [31:0]   reply_dl_ff, reply_dl_in;
   logic [1:0]    retry_ff, retry_in;
   logic          ready_ff, ready_in;
   logic          timeout_ff, timeout_in;
   logic          aborted_ff, aborted_in;
   logic          uss_ff, uss_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] run_left_ff, run_left_in;
   kind_type      run_kind_ff, run_kind_in;

   logic          rsp_valid_ff, rsp_valid_in;
   kind_type      rsp_kind_ff, rsp_kind_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_pop_ff, rsp_pop_in;
   logic          rsp_rdy_ff, rsp_rdy_in;
   logic          rsp_to_ff, rsp_to_in;
   logic          rsp_ab_ff, rsp_ab_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [SW-1:0] wr_sum;
   logic [7:0]    rd_data;
   logic          dispatch;
   kind_type      disp_kind;
   logic          rdy_v;
   logic          uss_v;
   logic          passed;
   logic [31:0]   recover_dl;

   assign now            = req_tdata[31:0];
   assign rx_valid       = req_tdata[32];
   assign rx_data        = req_tdata[40:33];
   assign ready_set      = req_tdata[41];
   assign ready_clear    = req_tdata[42];
   assign fmt_wait       = req_tdata[43];
   assign uss_wait_set   = req_tdata[44];
   assign alt_drive_wait = req_tdata[45];

   assign csr_ready = 1'b1;

   always_comb begin
      gap_ticks_in  = gap_ticks_ff;
      reply_wait_in = reply_wait_ff;
      recover_in    = recover_ff;
      max_retry_in  = max_retry_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GAP_TICKS:  gap_ticks_in  = csr_data[7:0];
            CSR_REPLY_WAIT: reply_wait_in = csr_data;
            CSR_RECOVER:    recover_in    = csr_data;
            CSR_MAX_RETRY:  max_retry_in  = csr_data[1:0];
            default:        gap_ticks_in  = gap_ticks_ff;
         endcase
      end
   end

   // frame store write address, head plus count folded into the store
   always_comb begin
      wr_sum = SW'(head_ff) + SW'(count_ff);
      if (wr_sum >= WRAP_SUM) begin
         wr_sum = wr_sum - WRAP_SUM;
      end
      wr_addr = wr_sum[AW-1:0];
   end

   assign uss_v = uss_ff | uss_wait_set;

   always_comb begin
      disp_kind = KIND_STATUS;
      if (!rx_valid && count_ff != '0 && reached(now, gap_dl_ff) && !fmt_wait) begin
         if (uss_v) begin
            disp_kind = KIND_USS;
         end else if (!alt_drive_wait) begin
            disp_kind = KIND_MODBUS;
         end
      end
      dispatch = (disp_kind != KIND_STATUS);
   end

   assign recover_dl = reply_dl_ff + 32'(recover_ff);
   assign passed     = reached(now, reply_dl_ff);

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      gap_dl_in   = gap_dl_ff;
      reply_dl_in = reply_dl_ff;
      retry_in    = retry_ff;
      ready_in    = ready_ff;
      timeout_in  = timeout_ff;
      aborted_in  = aborted_ff;
      uss_in      = uss_ff;
      rd_ptr_in   = rd_ptr_ff;
      run_left_in = run_left_ff;
      run_kind_in = run_kind_ff;
      wr_en       = 1'b0;
      rdy_v       = ready_ff;
      if (cmd.take) begin
         if (req_tuser) begin
            rd_ptr_in = head_ff;
            if (count_ff != '0) begin
               head_in  = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end
         end else begin
            if (ready_clear) begin
               rdy_v = 1'b0;
            end
            if (ready_set) begin
               rdy_v = 1'b1;
            end
            uss_in = uss_v;
            if (rx_valid) begin
               if (count_ff < FULL_COUNT) begin
                  wr_en     = 1'b1;
                  count_in  = count_ff + 1'b1;
                  gap_dl_in = now + 32'(gap_ticks_ff);
               end
            end else if (dispatch) begin
               if (disp_kind == KIND_USS) begin
                  uss_in = 1'b0;
               end
               run_kind_in = disp_kind;
               rd_ptr_in   = head_ff;
               run_left_in = count_ff;
               count_in    = '0;
               head_in     = '0;
            end
            ready_in = rdy_v;
            if (rdy_v) begin
               retry_in    = '0;
               timeout_in  = 1'b0;
               aborted_in  = 1'b0;
               reply_dl_in = now + 32'(reply_wait_ff);
            end else if (passed && !timeout_ff && retry_ff < max_retry_ff) begin
               retry_in    = retry_ff + 1'b1;
               timeout_in  = 1'b1;
               reply_dl_in = now + 32'(reply_wait_ff);
            end else if (passed && retry_ff >= max_retry_ff && !aborted_ff) begin
               aborted_in = 1'b1;
            end else if (reached(now, recover_dl)) begin
               retry_in   = '0;
               ready_in   = 1'b1;
               timeout_in = 1'b0;
               aborted_in = 1'b0;
               uss_in     = 1'b0;
            end
         end
      end
      if (cmd.rd_step) begin
         rd_ptr_in   = (rd_ptr_ff == LAST_ADDR) ? '0 : rd_ptr_ff + 1'b1;
         run_left_in = run_left_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_pop_in   = rsp_pop_ff;
      rsp_rdy_in   = rsp_rdy_ff;
      rsp_to_in    = rsp_to_ff;
      rsp_ab_in    = rsp_ab_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.last;
         rsp_rdy_in   = ready_ff;
         rsp_to_in    = timeout_ff;
         rsp_ab_in    = aborted_ff;
         unique case (cmd.sel)
            SEL_POP: begin
               rsp_kind_in = KIND_POP;
               rsp_data_in = rd_data;
               rsp_pop_in  = 1'b1;
            end
            SEL_RUN: begin
               rsp_kind_in = run_kind_ff;
               rsp_data_in = rd_data;
               rsp_pop_in  = 1'b0;
            end
            default: begin
               rsp_kind_in = KIND_STATUS;
               rsp_data_in = 8'd0;
               rsp_pop_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff  <= GAP_TICKS_RST;
         reply_wait_ff <= REPLY_WAIT_RST;
         recover_ff    <= RECOVER_RST;
         max_retry_ff  <= MAX_RETRY_RST;
         head_ff       <= '0;
         count_ff      <= '0;
         gap_dl_ff     <= '0;
         reply_dl_ff   <= '0;
         retry_ff      <= '0;
         ready_ff      <= 1'b1;
         timeout_ff    <= 1'b0;
         aborted_ff    <= 1'b0;
         uss_ff        <= 1'b0;
         rd_ptr_ff     <= '0;
         run_left_ff   <= '0;
         run_kind_ff   <= KIND_STATUS;
         rsp_valid_ff  <= 1'b0;
      end else begin
         gap_ticks_ff  <= gap_ticks_in;
         reply_wait_ff <= reply_wait_in;
         recover_ff    <= recover_in;
         max_retry_ff  <= max_retry_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         gap_dl_ff     <= gap_dl_in;
         reply_dl_ff   <= reply_dl_in;
         retry_ff      <= retry_in;
         ready_ff      <= ready_in;
         timeout_ff    <= timeout_in;
         aborted_ff    <= aborted_in;
         uss_ff        <= uss_in;
         rd_ptr_ff     <= rd_ptr_in;
         run_left_ff   <= run_left_in;
         run_kind_ff   <= run_kind_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_pop_ff  <= rsp_pop_in;
      rsp_rdy_ff  <= rsp_rdy_in;
      rsp_to_ff   <= rsp_to_in;
      rsp_ab_ff   <= rsp_ab_in;
   end

   sfgrw_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx_data),
      .rd_en   (cmd.rd_step),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   assign sts.is_pop   = req_tuser;
   assign sts.pop_hit  = (count_ff != '0);
   assign sts.dispatch = dispatch;
   assign sts.run_done = (run_left_ff == '0);
   assign sts.out_free = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_ab_ff, rsp_to_ff, rsp_rdy_ff, rsp_pop_ff, rsp_data_ff};

endmodule

// ----- src/sfgrw_ctrl.sv -----
// Controller: sequences request intake, store reads and result loads.
module sfgrw_ctrl
   import sfgrw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.take    = 1'b0;
      cmd.rd_step = 1'b0;
      cmd.load    = 1'b0;
      cmd.sel     = SEL_STATUS;
      cmd.last    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (sts.is_pop) begin
                  state_in = sts.pop_hit ? ST_POP_RD : ST_STAT_OUT;
               end else begin
                  state_in = sts.dispatch ? ST_RUN_RD : ST_STAT_OUT;
               end
            end
         end
         ST_STAT_OUT: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_POP_RD: begin
            cmd.rd_step = 1'b1;
            state_in    = ST_POP_OUT;
         end
         ST_POP_OUT: begin
            cmd.sel = SEL_POP;
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RUN_RD: begin
            cmd.rd_step = 1'b1;
            state_in    = ST_RUN_OUT;
         end
         ST_RUN_OUT: begin
            cmd.sel  = SEL_RUN;
            cmd.last = sts.run_done;
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = sts.run_done ? ST_IDLE : ST_RUN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/serial_frame_gap_and_retry_watchdog_top.sv -----
// Top level of the serial frame gap and retry watchdog block.
// Takes one request at a time. A handler pass that sends no frame, and a pop of an
// empty store, go through the accept state, then one that loads the status result
// into the output register. A pop that finds a byte goes through the accept, store
// read and result load states. A pass that closes a frame of n bytes goes through the
// accept state, then one store read and one result load per byte through the single
// read port of the frame store. A result waiting in the output register does not hold
// off the next request, but each load waits until that register is free. The frame
// store needs no clearing after reset; configuration writes are taken any cycle.
`include "serial_frame_gap_and_retry_watchdog_top_macros.svh"

module serial_frame_gap_and_retry_watchdog_top
   import sfgrw_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // cycle_now[31:0], rx_valid[32], rx_data[40:33], ready_set[41], ready_clear[42],
   // fmt_wait[43], uss_wait_set[44], alt_drive_wait[45], zero fill above
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // req_type[0]
   input  logic                   req_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_data[7:0], pop_ok[8], ready_flag[9], timeout_flag[10], aborted_flag[11],
   // zero fill above
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // out_kind[1:0]
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   sfgrw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sfgrw_dp #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `SFGR_ASSERT_NEXT(a_one_request_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `SFGR_ASSERT_SAME(a_pop_ok_matches_kind, clock, reset, rsp_tvalid, (rsp_tuser == KIND_POP) == rsp_tdata[8])
   `SFGR_ASSERT_SAME(a_status_is_single, clock, reset, rsp_tvalid && (rsp_tuser == KIND_STATUS), rsp_tlast && (rsp_tdata[7:0] == 8'd0))

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the frame gap receiver and retry watchdog: predicts and checks every result.
module testbench;
   import sfgrw_pkg::*;

   localparam int FIFO_DEPTH  = STORE_DEPTH_DEF;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_TAIL  = 160;
   localparam int HOLD_LEN    = 300;
   localparam int MAX_PRINTS  = 40;

   typedef struct packed {
      logic        is_pop;
      logic [31:0] now;
      logic        rx_valid;
      logic [7:0]  rx_data;
      logic        ready_set;
      logic        ready_clear;
      logic        fmt_wait;
      logic        uss_wait_set;
      logic        alt_drive_wait;
   } rx_request_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
      logic       pop_ok;
      logic       ready;
      logic       timeout;
      logic       aborted;
   } rx_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;

   // predicted block state
   logic [7:0]  fifo_bytes [FIFO_DEPTH];
   int unsigned fifo_head;
   int unsigned fifo_fill;
   logic [31:0] gap_deadline;
   logic [31:0] reply_deadline;
   logic [1:0]  retry_count;
   logic        ready_st;
   logic        timeout_st;
   logic        aborted_st;
   logic        uss_pending;
   logic [7:0]  gap_ticks_cfg;
   logic [15:0] reply_wait_cfg;
   logic [15:0] recover_cfg;
   logic [1:0]  max_retry_cfg;

   rx_result_type pending_rx_results [$];
   int unsigned mismatch_count;
   int unsigned items_sent;
   int unsigned quiet_cycles;
   int unsigned rsp_hold_len;
   logic [31:0] tick;
   logic        req_idle_on;
   logic        rsp_stall_on;

   serial_frame_gap_and_retry_watchdog_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic tick_reached(input logic [31:0] now, input logic [31:0] mark);
      logic [31:0] diff;
      diff = now - mark;
      return !diff[31];
   endfunction

   function automatic void predict_rx_step(input rx_request_type rq);
      rx_result_type res;
      logic [7:0]  frame [FIFO_DEPTH];
      int unsigned run_len;
      int unsigned i;
      kind_type    run_kind;
      logic        passed;
      run_len  = 0;
      run_kind = KIND_STATUS;
      res.kind   = KIND_STATUS;
      res.data   = 8'h00;
      res.last   = 1'b1;
      res.pop_ok = 1'b0;
      if (rq.is_pop) begin
         if (fifo_fill > 0) begin
            res.kind   = KIND_POP;
            res.data   = fifo_bytes[fifo_head];
            res.pop_ok = 1'b1;
            fifo_head  = (fifo_head + 1) % FIFO_DEPTH;
            fifo_fill  = fifo_fill - 1;
         end
      end else begin
         if (rq.ready_clear) ready_st = 1'b0;
         if (rq.ready_set) ready_st = 1'b1;
         if (rq.uss_wait_set) uss_pending = 1'b1;
         if (rq.rx_valid) begin
            if (fifo_fill < FIFO_DEPTH) begin
               fifo_bytes[(fifo_head + fifo_fill) % FIFO_DEPTH] = rq.rx_data;
               fifo_fill    = fifo_fill + 1;
               gap_deadline = rq.now + {24'd0, gap_ticks_cfg};
            end
         end else if (fifo_fill > 0 && tick_reached(rq.now, gap_deadline) && !rq.fmt_wait) begin
            if (uss_pending) begin
               run_kind    = KIND_USS;
               uss_pending = 1'b0;
            end else if (!rq.alt_drive_wait) begin
               run_kind = KIND_MODBUS;
            end
            if (run_kind != KIND_STATUS) begin
               run_len = fifo_fill;
               for (i = 0; i < run_len; i++) frame[i] = fifo_bytes[(fifo_head + i) % FIFO_DEPTH];
               fifo_fill = 0;
               fifo_head = 0;
            end
         end
         if (ready_st) begin
            retry_count    = 2'd0;
            timeout_st     = 1'b0;
            aborted_st     = 1'b0;
            reply_deadline = rq.now + {16'd0, reply_wait_cfg};
         end else begin
            passed = tick_reached(rq.now, reply_deadline);
            if (passed && !timeout_st && retry_count < max_retry_cfg) begin
               retry_count    = retry_count + 2'd1;
               timeout_st     = 1'b1;
               reply_deadline = rq.now + {16'd0, reply_wait_cfg};
            end else if (passed && retry_count >= max_retry_cfg && !aborted_st) begin
               aborted_st = 1'b1;
            end else if (tick_reached(rq.now, reply_deadline + {16'd0, recover_cfg})) begin
               retry_count = 2'd0;
               ready_st    = 1'b1;
               timeout_st  = 1'b0;
               aborted_st  = 1'b0;
               uss_pending = 1'b0;
            end
         end
      end
      res.ready   = ready_st;
      res.timeout = timeout_st;
      res.aborted = aborted_st;
      if (run_len == 0) begin
         pending_rx_results.push_back(res);
      end else begin
         for (i = 0; i < run_len; i++) begin
            res.kind = run_kind;
            res.data = frame[i];
            res.last = (i + 1 == run_len);
            pending_rx_results.push_back(res);
         end
      end
   endfunction

   function automatic rx_request_type random_request();
      rx_request_type rq;
      rq.is_pop         = 1'($urandom_range(0, 1));
      rq.now            = $urandom;
      rq.rx_valid       = 1'($urandom_range(0, 1));
      rq.rx_data        = 8'($urandom);
      rq.ready_set      = 1'($urandom_range(0, 1));
      rq.ready_clear    = 1'($urandom_range(0, 1));
      rq.fmt_wait       = 1'($urandom_range(0, 1));
      rq.uss_wait_set   = 1'($urandom_range(0, 1));
      rq.alt_drive_wait = 1'($urandom_range(0, 1));
      return rq;
   endfunction

   function automatic logic rare_flag();
      return ($urandom_range(0, 7) == 0);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("check failed at %0t: %s got %0h want %0h", $time, what, got, want);
   endtask

   task automatic send_request(input rx_request_type rq);
      int unsigned pause;
      req_tdata  <= {2'b00, rq.alt_drive_wait, rq.uss_wait_set, rq.fmt_wait, rq.ready_clear,
                     rq.ready_set, rq.rx_data, rq.rx_valid, rq.now};
      req_tuser  <= rq.is_pop;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_rx_step(rq);
      items_sent++;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         pause = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
   endtask

   task automatic handler_pass(input logic [31:0] now, input logic rxv, input logic [7:0] rxd,
                               input logic rset, input logic rclr, input logic fmt,
                               input logic ussw, input logic altw);
      rx_request_type rq;
      rq.is_pop         = 1'b0;
      rq.now            = now;
      rq.rx_valid       = rxv;
      rq.rx_data        = rxd;
      rq.ready_set      = rset;
      rq.ready_clear    = rclr;
      rq.fmt_wait       = fmt;
      rq.uss_wait_set   = ussw;
      rq.alt_drive_wait = altw;
      send_request(rq);
   endtask

   task automatic pop_request();
      rx_request_type rq;
      rq        = random_request();
      rq.is_pop = 1'b1;
      send_request(rq);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rx_results.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GAP_TICKS:  gap_ticks_cfg  = value[7:0];
         CSR_REPLY_WAIT: reply_wait_cfg = value;
         CSR_RECOVER:    recover_cfg    = value;
         CSR_MAX_RETRY:  max_retry_cfg  = value[1:0];
         default: ;
      endcase
   endtask

   task automatic random_traffic(input int unsigned quota);
      int unsigned stop_at;
      int unsigned len;
      int unsigned pick;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 19);
         if (pick < 11) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
            repeat (len) begin
               tick += $urandom_range(0, gap_ticks_cfg);
               handler_pass(tick, 1'b1, 8'($urandom), rare_flag(), rare_flag(), rare_flag(),
                            rare_flag(), rare_flag());
            end
            if (gap_ticks_cfg > 1 && $urandom_range(0, 2) == 0)
               handler_pass(tick + $urandom_range(0, gap_ticks_cfg - 1), 1'b0, 8'($urandom),
                            rare_flag(), rare_flag(), 1'b0, rare_flag(), 1'b0);
            tick += gap_ticks_cfg + $urandom_range(0, 2);
            handler_pass(tick, 1'b0, 8'($urandom), rare_flag(), rare_flag(), rare_flag(),
                         rare_flag(), rare_flag());
         end else if (pick < 14) begin
            handler_pass(tick, 1'b0, 8'($urandom), 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
            repeat ($urandom_range(2, 8)) begin
               tick += $urandom_range(0, reply_wait_cfg + recover_cfg / 2 + 1);
               handler_pass(tick, 1'b0, 8'($urandom), 1'b0, 1'b0, rare_flag(), rare_flag(),
                            rare_flag());
            end
         end else if (pick < 17) begin
            repeat ($urandom_range(1, 4)) pop_request();
         end else if (pick < 19) begin
            send_request(random_request());
         end else begin
            tick += $urandom;
            handler_pass(tick, 1'b0, 8'($urandom), rare_flag(), rare_flag(), rare_flag(),
                         rare_flag(), rare_flag());
         end
      end
   endtask

   task automatic test_directed_cases();
      pop_request();
      handler_pass(32'd1000, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'd1001, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'd1002, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'd1004, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'd1005, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
      handler_pass(32'd1005, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      handler_pass(32'd1006, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'd1010, 1'b1, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'd1011, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      handler_pass(32'd1013, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      handler_pass(32'd1020, 1'b1, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      pop_request();
      pop_request();
      handler_pass(32'd1030, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      handler_pass(32'd1040, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      handler_pass(32'd1080, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'd1130, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'd1200, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      handler_pass(32'd1380, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'd1400, 1'b1, 8'h11, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'd1403, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'hFFFF_FFFE, 1'b1, 8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'h8000_0002, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      handler_pass(32'h0000_0001, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      tick = 32'd2000;
   endtask

   task automatic test_store_full_backpressure();
      logic [31:0] last_kept;
      rsp_hold_len = HOLD_LEN;
      while (fifo_fill < FIFO_DEPTH) begin
         tick += 1;
         handler_pass(tick, 1'b1, 8'($urandom), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      end
      last_kept = tick;
      // dropped bytes must not push the gap deadline out
      repeat (6) begin
         tick += 1;
         handler_pass(tick, 1'b1, 8'($urandom), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      end
      handler_pass(last_kept + gap_ticks_cfg, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      rsp_hold_len = HOLD_LEN;
      tick += gap_ticks_cfg;
      random_traffic(20);
   endtask

   task automatic test_config_setting(input logic [7:0] gap, input logic [15:0] reply,
                                      input logic [15:0] recover, input logic [1:0] retries,
                                      input int unsigned quota);
      wait_drained();
      write_csr(CSR_GAP_TICKS, {8'($urandom), gap});
      write_csr(CSR_REPLY_WAIT, reply);
      write_csr(CSR_RECOVER, recover);
      write_csr(CSR_MAX_RETRY, {14'($urandom), retries});
      write_csr(8'($urandom_range(4, 255)), 16'($urandom));
      csr_valid <= 1'b0;
      random_traffic(quota);
   endtask

   task automatic test_unthrottled_traffic();
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b0;
      random_traffic(60);
   endtask

   initial begin : rsp_side
      int unsigned pause;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len > 0) begin
            pause        = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end else if (rsp_stall_on && $urandom_range(0, 5) == 0) begin
            pause = $urandom_range(1, 6);
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      rx_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rx_results.size() == 0) begin
            report_mismatch("unexpected result", {rsp_tuser, rsp_tdata}, 32'd0);
         end else begin
            want = pending_rx_results.pop_front();
            if (rsp_tuser != want.kind) report_mismatch("out_kind", rsp_tuser, want.kind);
            if (rsp_tdata[7:0] != want.data) report_mismatch("out_data", rsp_tdata[7:0], want.data);
            if (rsp_tlast != want.last) report_mismatch("out_last", rsp_tlast, want.last);
            if (rsp_tdata[8] != want.pop_ok) report_mismatch("pop_ok", rsp_tdata[8], want.pop_ok);
            if (rsp_tdata[9] != want.ready) report_mismatch("ready_flag", rsp_tdata[9], want.ready);
            if (rsp_tdata[10] != want.timeout)
               report_mismatch("timeout_flag", rsp_tdata[10], want.timeout);
            if (rsp_tdata[11] != want.aborted)
               report_mismatch("aborted_flag", rsp_tdata[11], want.aborted);
            if (rsp_tdata[RSP_DATA_W-1:12] != '0)
               report_mismatch("tdata fill", rsp_tdata[RSP_DATA_W-1:12], 32'd0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("serial_frame_gap_and_retry_watchdog_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      fifo_head      = 0;
      fifo_fill      = 0;
      gap_deadline   = 32'd0;
      reply_deadline = 32'd0;
      retry_count    = 2'd0;
      ready_st       = 1'b1;
      timeout_st     = 1'b0;
      aborted_st     = 1'b0;
      uss_pending    = 1'b0;
      gap_ticks_cfg  = GAP_TICKS_RST;
      reply_wait_cfg = REPLY_WAIT_RST;
      recover_cfg    = RECOVER_RST;
      max_retry_cfg  = MAX_RETRY_RST;
      mismatch_count = 0;
      items_sent     = 0;
      quiet_cycles   = 0;
      rsp_hold_len   = 0;
      tick           = 32'd1000;
      req_idle_on    = 1'b1;
      rsp_stall_on   = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_store_full_backpressure();
      test_config_setting(8'd1, 16'd1, 16'd1, 2'd0, 40);
      test_config_setting(8'd255, 16'd65535, 16'd65535, 2'd3, 40);
      test_config_setting(8'($urandom_range(2, 40)), 16'($urandom_range(2, 500)),
                          16'($urandom_range(2, 900)), 2'd2, 40);
      test_config_setting(GAP_TICKS_RST, REPLY_WAIT_RST, RECOVER_RST, MAX_RETRY_RST, 40);
      test_unthrottled_traffic();
      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatch_count == 0 && pending_rx_results.size() == 0) begin
         $display("serial_frame_gap_and_retry_watchdog_top: match");
      end else begin
         $display("serial_frame_gap_and_retry_watchdog_top: mismatch");
      end
      $finish;
   end

endmodule
